// ===== rtl/multi_channel_task_watchdog_macros.svh =====
// Assertion macros shared by the watchdog RTL.
// Both macros check on the rising clock edge and stay quiet while reset is applied.
`ifndef MULTI_CHANNEL_TASK_WATCHDOG_MACROS_SVH
`define MULTI_CHANNEL_TASK_WATCHDOG_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold in the same cycle.
`define MCTW_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("mctw assertion failed");

// When the condition holds, the consequence must hold in the next cycle.
`define MCTW_ASSERT_NEXT(label, clk, rst_n, cond, conseq) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
		else $error("mctw assertion failed");

`else

`define MCTW_ASSERT(label, clk, rst_n, prop)
`define MCTW_ASSERT_NEXT(label, clk, rst_n, cond, conseq)

`endif

`endif

// ===== rtl/mctw_pkg.sv =====
package mctw_pkg;

	localparam int CHANNELS = 12;
	localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CNT_W    = 4;
	localparam int OP_W     = 3;
	localparam int CHAN_W   = 8;
	localparam int HANDLE_W = 4;
	localparam int PER_W    = 16;
	localparam int TOT_W    = 32;
	localparam int ADDR_W   = 3;
	localparam int DATA_W   = 32;

	localparam logic [OP_W-1:0] OP_REGISTER = 3'd0;
	localparam logic [OP_W-1:0] OP_ENABLE   = 3'd1;
	localparam logic [OP_W-1:0] OP_DISABLE  = 3'd2;
	localparam logic [OP_W-1:0] OP_REFRESH  = 3'd3;
	localparam logic [OP_W-1:0] OP_TICK     = 3'd4;
	localparam logic [OP_W-1:0] OP_QUERY    = 3'd5;

	localparam logic [HANDLE_W-1:0] HANDLE_FULL = '1;

	// Register index of the feed override, taken from byte address bit 2.
	localparam logic REG_FEED_DESPITE_FAIL = 1'b0;

	// Per-cycle update requests toward the channel bank.
	typedef struct packed {
		logic                alloc;
		logic [IDX_W-1:0]    alloc_idx;
		logic                tick;
		logic                set_en;
		logic                clr_en;
		logic                refresh;
		logic [IDX_W-1:0]    idx;
		logic [CHANNELS-1:0] reg_mask;
	} mctw_cmd_t;

	// State of the addressed channel after the update, plus the tick verdict.
	typedef struct packed {
		logic                en;
		logic [PER_W-1:0]    per;
		logic [TOT_W-1:0]    tot;
		logic [CHANNELS-1:0] fails;
	} mctw_view_t;

endpackage

// ===== rtl/mctw_chan_bank.sv =====
module mctw_chan_bank import mctw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  mctw_cmd_t  cmd,
	output mctw_view_t view
);

	logic             en_q   [CHANNELS];
	logic             ref_q  [CHANNELS];
	logic [PER_W-1:0] per_q  [CHANNELS];
	logic [TOT_W-1:0] tot_q  [CHANNELS];

	logic             en_n   [CHANNELS];
	logic             ref_n  [CHANNELS];
	logic [PER_W-1:0] per_n  [CHANNELS];
	logic [TOT_W-1:0] tot_n  [CHANNELS];

	logic [CHANNELS-1:0] fails;

	always_comb begin
		for (int i = 0; i < CHANNELS; i++) begin
			en_n[i]  = en_q[i];
			ref_n[i] = ref_q[i];
			per_n[i] = per_q[i];
			tot_n[i] = tot_q[i];
			// A channel fails a tick when it is enabled but saw no refresh.
			// Unregistered channels are never enabled and keep their mark set.
			fails[i] = cmd.tick & en_q[i] & ~ref_q[i];
			if (cmd.alloc && cmd.alloc_idx == IDX_W'(i)) begin
				en_n[i] = 1'b1;
			end
			if (cmd.set_en && cmd.idx == IDX_W'(i)) begin
				en_n[i] = 1'b1;
			end
			if (cmd.clr_en && cmd.idx == IDX_W'(i)) begin
				en_n[i] = 1'b0;
			end
			if (cmd.refresh && cmd.idx == IDX_W'(i)) begin
				ref_n[i] = 1'b1;
				if (per_q[i] != '1) begin
					per_n[i] = per_q[i] + 1'b1;
				end
				if (tot_q[i] != '1) begin
					tot_n[i] = tot_q[i] + 1'b1;
				end
			end
			if (cmd.tick && cmd.reg_mask[i]) begin
				ref_n[i] = 1'b0;
				per_n[i] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				en_q[i]  <= 1'b0;
				ref_q[i] <= 1'b1;
				per_q[i] <= '0;
				tot_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < CHANNELS; i++) begin
				en_q[i]  <= en_n[i];
				ref_q[i] <= ref_n[i];
				per_q[i] <= per_n[i];
				tot_q[i] <= tot_n[i];
			end
		end
	end

	assign view.en    = en_n[cmd.idx];
	assign view.per   = per_n[cmd.idx];
	assign view.tot   = tot_n[cmd.idx];
	assign view.fails = fails;

endmodule

// ===== rtl/multi_channel_task_watchdog.sv =====
// Channel   Handshake                        Transaction content
// command   start (busy is always low)       opcode, channel
// result    done, one cycle, no back-pressure handle, error, enabled, counters, tick verdict
// config    APB write, pready always high    feed_despite_fail at byte address 0
//
// A command transaction is captured into the input register, and its result appears on
// the result ports at the next edge, marked by done for one cycle. A new command may be
// accepted on every cycle, so one transaction per cycle is sustained; the per-channel state
// update and the result register share one clock edge.
// arst_n clears all control and channel state asynchronously; there is no clearing pass.
// The receiver cannot stall, so results are never held and busy never rises.
`include "multi_channel_task_watchdog_macros.svh"

module multi_channel_task_watchdog import mctw_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [OP_W-1:0]     opcode,
	input  logic [CHAN_W-1:0]   channel,
	output logic                done,
	output logic [HANDLE_W-1:0] handle,
	output logic                error,
	output logic                enabled,
	output logic [PER_W-1:0]    period_refreshes,
	output logic [TOT_W-1:0]    total_refreshes,
	output logic [CHANNELS-1:0] fail_mask,
	output logic                feed,
	output logic                reset_latched,
	output logic [CNT_W-1:0]    registered_count,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]   pwdata,
	output logic [DATA_W-1:0]   prdata,
	output logic                pready
);

	// The command port never refuses a transaction.
	assign busy   = 1'b0;
	assign pready = 1'b1;

	// Configuration register. Bit 2 of the byte address selects the register;
	// writes to any other register index are dropped.
	logic fdf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fdf_q <= 1'b0;
		end else if (psel && penable && pwrite && paddr[2] == REG_FEED_DESPITE_FAIL) begin
			fdf_q <= pwdata[0];
		end
	end

	assign prdata = (paddr[2] == REG_FEED_DESPITE_FAIL) ? {{(DATA_W-1){1'b0}}, fdf_q} : '0;

	// Input register stage.
	logic              vld_s1;
	logic [OP_W-1:0]   op_s1;
	logic [CHAN_W-1:0] ch_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_s1 <= opcode;
			ch_s1 <= channel;
		end
	end

	// Global control state.
	logic [CNT_W-1:0] count_q;
	logic             reset_req_q;

	logic                full;
	logic                ch_valid;
	logic [CHANNELS-1:0] reg_mask;
	mctw_cmd_t           cmd;
	mctw_view_t          view;
	logic                req_n;

	assign full     = count_q >= CNT_W'(CHANNELS);
	assign ch_valid = ch_s1 < {{(CHAN_W-CNT_W){1'b0}}, count_q};

	always_comb begin
		for (int i = 0; i < CHANNELS; i++) begin
			reg_mask[i] = count_q > CNT_W'(i);
		end
	end

	// Decode the captured command into bank updates. The channel index is only
	// used when the channel has been checked against the registered count.
	always_comb begin
		cmd.alloc     = vld_s1 && op_s1 == OP_REGISTER && !full;
		cmd.alloc_idx = count_q[IDX_W-1:0];
		cmd.tick      = vld_s1 && op_s1 == OP_TICK;
		cmd.set_en    = vld_s1 && op_s1 == OP_ENABLE && ch_valid;
		cmd.clr_en    = vld_s1 && op_s1 == OP_DISABLE && ch_valid;
		cmd.refresh   = vld_s1 && op_s1 == OP_REFRESH && ch_valid;
		cmd.idx       = ch_s1[IDX_W-1:0];
		cmd.reg_mask  = reg_mask;
	end

	mctw_chan_bank u_bank (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.view   (view)
	);

	// Any failing channel on a tick latches the reset request for good.
	assign req_n = reset_req_q | (|view.fails);

	// Result assembly.
	logic [HANDLE_W-1:0] handle_n;
	logic                error_n;
	logic                en_n;
	logic [PER_W-1:0]    per_n;
	logic [TOT_W-1:0]    tot_n;
	logic [CHANNELS-1:0] fails_n;
	logic                feed_n;

	always_comb begin
		handle_n = ch_s1[HANDLE_W-1:0];
		error_n  = 1'b0;
		en_n     = 1'b0;
		per_n    = '0;
		tot_n    = '0;
		fails_n  = '0;
		feed_n   = 1'b0;
		case (op_s1)
			OP_REGISTER: begin
				// A fresh handle has never been refreshed or counted, so its
				// counters read as zero.
				if (full) begin
					handle_n = HANDLE_FULL;
					error_n  = 1'b1;
				end else begin
					handle_n = HANDLE_W'(count_q);
					en_n     = 1'b1;
				end
			end
			OP_TICK: begin
				handle_n = '0;
				fails_n  = view.fails;
				feed_n   = !req_n || fdf_q;
			end
			OP_ENABLE, OP_DISABLE, OP_REFRESH, OP_QUERY: begin
				if (ch_valid) begin
					en_n  = view.en;
					per_n = view.per;
					tot_n = view.tot;
				end else begin
					error_n = 1'b1;
				end
			end
			default: begin
				error_n = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			reset_req_q <= 1'b0;
			done        <= 1'b0;
		end else begin
			done <= vld_s1;
			if (cmd.alloc) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.tick) begin
				reset_req_q <= req_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			handle           <= handle_n;
			error            <= error_n;
			enabled          <= en_n;
			period_refreshes <= per_n;
			total_refreshes  <= tot_n;
			fail_mask        <= fails_n;
			feed             <= feed_n;
			reset_latched    <= req_n;
			registered_count <= cmd.alloc ? count_q + 1'b1 : count_q;
		end
	end

	// Every accepted command produces exactly one result; done follows the input register's valid bit.
	`MCTW_ASSERT_NEXT(a_done_follows, clk, arst_n, vld_s1, done)
	// The registered count never runs past the channel table.
	`MCTW_ASSERT(a_count_bound, clk, arst_n, count_q <= CNT_W'(CHANNELS))
	// The reset request is sticky.
	`MCTW_ASSERT_NEXT(a_req_sticky, clk, arst_n, reset_req_q, reset_req_q)
	// A reported failure always comes with a latched reset request.
	`MCTW_ASSERT(a_fail_latches, clk, arst_n, !(done && fail_mask != '0) || reset_latched)
	// A feed with a latched request is only allowed under the override.
	`MCTW_ASSERT(a_feed_gate, clk, arst_n, !(done && feed && reset_latched) || fdf_q)

endmodule
